// ----- hw/rtl/mpos_pkg.sv -----
// ----------------------------------------------------------------------------
// mpos_pkg: shared definitions for the polyphonic oscillator synthesizer
// Event and controller codes, waveform codes, configuration register indexes,
// sequencer states and the note pitch table.
// ----------------------------------------------------------------------------
package mpos_pkg;

    localparam int          CHANNELS     = 16;
    localparam logic [3:0]  PERC_CHANNEL = 4'd9;
    localparam logic [31:0] NOISE_SEED   = 32'h13579bdf;
    localparam logic [6:0]  VOL_DEFAULT  = 7'd100;
    localparam logic [6:0]  GAIN_MAX     = 7'd127;

    // Event codes carried in the mode field.
    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_NOTE_ON  = 3'd1;
    localparam logic [2:0] MODE_NOTE_OFF = 3'd2;
    localparam logic [2:0] MODE_PROGRAM  = 3'd3;
    localparam logic [2:0] MODE_CTRL     = 3'd4;
    localparam logic [2:0] MODE_SILENCE  = 3'd5;
    localparam logic [2:0] MODE_RESTART  = 3'd6;
    localparam logic [2:0] MODE_UNUSED   = 3'd7;

    // Controller numbers that have an effect.
    localparam logic [6:0] CC_VOLUME  = 7'd7;
    localparam logic [6:0] CC_ALL_OFF = 7'd123;

    // Waveform codes.
    localparam logic [2:0] WAVE_TRI    = 3'd0;
    localparam logic [2:0] WAVE_SQUARE = 3'd1;
    localparam logic [2:0] WAVE_SAW    = 3'd2;
    localparam logic [2:0] WAVE_PULSE  = 3'd3;
    localparam logic [2:0] WAVE_NOISE  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MASTER = 2'd0;
    localparam logic [1:0] CFG_PERC   = 2'd1;
    localparam logic [1:0] CFG_HALF   = 2'd2;

    // x / 100 for x below 16384 is (x * 5243) >> 19.
    localparam logic [17:0] DIV100_RECIP = 18'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PICK,
        ST_START,
        ST_SEL,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_G4,
        ST_G5,
        ST_WAVE,
        ST_ACC,
        ST_OUT
    } state_t;

    function automatic logic [31:0] base_step(input logic [3:0] r);
        logic [31:0] s;
        case (r)
            4'd0:    s = 32'd796279;
            4'd1:    s = 32'd843631;
            4'd2:    s = 32'd893796;
            4'd3:    s = 32'd946939;
            4'd4:    s = 32'd1003255;
            4'd5:    s = 32'd1062913;
            4'd6:    s = 32'd1126119;
            4'd7:    s = 32'd1193088;
            4'd8:    s = 32'd1264052;
            4'd9:    s = 32'd1339218;
            4'd10:   s = 32'd1418887;
            4'd11:   s = 32'd1503294;
            default: s = 32'd0;
        endcase
        return s;
    endfunction

    // Phase step of a note: the base step of its pitch class shifted by its
    // octave. The octave is note / 12, taken as (note * 43) >> 9.
    function automatic logic [31:0] pitch_step(input logic [6:0] note, input logic half);
        logic [12:0] prod;
        logic [3:0]  oct;
        logic [6:0]  rem;
        logic [31:0] s;
        prod = 13'(note) * 13'd43;
        oct  = prod[12:9];
        rem  = note - 7'({3'b000, oct} * 7'd12);
        s    = base_step(rem[3:0]) << oct;
        if (half)
        begin
            s = s << 1;
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/mpos_mul.sv -----
// ----------------------------------------------------------------------------
// mpos_mul: shared registered multiplier
// One signed 18 by 18 multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module mpos_mul
(
    input  logic                clk,
    input  logic signed [17:0]  a,
    input  logic signed [17:0]  b,
    output logic signed [35:0]  prod
);

    logic signed [35:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/midi_polyphonic_oscillator_synth.sv -----
// ----------------------------------------------------------------------------
// midi_polyphonic_oscillator_synth: polyphonic MIDI oscillator synthesizer
// Event decoder, voice allocator and sample renderer around one multiplier.
// ----------------------------------------------------------------------------
// A user sees one input word per MIDI event or sample tick. Events that only
// touch channel or voice flags (note off, program, controllers, silence,
// restart, note on with velocity zero) finish in the cycle they are accepted,
// so the block is ready again in the next cycle. A note on scans the voices
// one per cycle to pick one, then writes it. A sample tick walks the voices
// in turn; an inactive voice only passes through state SEL, while an active
// voice goes through SEL, G1, G2, G3, WAVE and ACC (and G4 and G5 as well on
// channel nine), because the gain product, the percussion percentage and the
// wave times gain all go through the single shared multiplier in turn. The
// finished sample sits in an output register; events are taken while it
// waits, and only the next tick holds at its end until the previous sample
// has been taken. Configuration writes are always accepted and take effect
// at once.
// ----------------------------------------------------------------------------
module midi_polyphonic_oscillator_synth
    import mpos_pkg::*;
#(
    parameter int VOICES = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          mode,
    input  logic [3:0]          channel,
    input  logic [6:0]          key,
    input  logic [6:0]          value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  sample,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);
    localparam int ACC_W = 24;

    // Configuration registers.
    logic [6:0] master_reg;
    logic [6:0] perc_reg;
    logic       half_reg;

    // Voice and channel state.
    logic [31:0] phase_reg   [VOICES];
    logic [31:0] step_reg    [VOICES];
    logic [31:0] age_reg     [VOICES];
    logic [6:0]  note_reg    [VOICES];
    logic [3:0]  vchan_reg   [VOICES];
    logic [6:0]  vel_reg     [VOICES];
    logic [2:0]  wf_reg      [VOICES];
    logic [VOICES-1:0] active_reg;
    logic [6:0]  chvol_reg   [CHANNELS];
    logic [6:0]  prog_reg    [CHANNELS];
    logic [31:0] counter_reg;
    logic [31:0] noise_reg;

    // Sequencer and working registers.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  old_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [3:0]        ch_reg;
    logic [6:0]        key_reg;
    logic [6:0]        val_reg;
    logic [6:0]        gain_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] sample_reg;
    logic              out_valid_reg;

    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] prod;

    logic              is_last;
    logic              found;
    logic [IDX_W-1:0]  old_cand;
    logic              out_free;
    logic              in_fire;
    logic [6:0]        gain_g3;
    logic [8:0]        gain_q;
    logic [6:0]        gain_g5;
    logic [31:0]       noise_a;
    logic [31:0]       noise_b;
    logic [31:0]       noise_c;
    logic [31:0]       ph;
    logic signed [17:0] tri_lin;
    logic signed [17:0] wave;
    logic signed [ACC_W-1:0] term;
    logic signed [15:0] mix_clamped;

    mpos_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign is_last  = (idx_reg == LAST_IDX);
    assign found    = !active_reg[idx_reg]
                    || (vchan_reg[idx_reg] == ch_reg && note_reg[idx_reg] == key_reg);
    assign old_cand = (age_reg[idx_reg] < age_reg[old_reg]) ? idx_reg : old_reg;

    // Gain after the master volume multiply is bits 20:14 of the product.
    assign gain_g3 = prod[20:14];
    assign gain_q  = prod[DIV100_SHIFT+8:DIV100_SHIFT];
    assign gain_g5 = (gain_q > 9'(GAIN_MAX)) ? GAIN_MAX : gain_q[6:0];

    // One xorshift step of the shared noise register.
    assign noise_a = noise_reg ^ (noise_reg << 13);
    assign noise_b = noise_a ^ (noise_a >> 17);
    assign noise_c = noise_b ^ (noise_b << 5);

    assign ph      = phase_reg[idx_reg];
    assign tri_lin = $signed({1'b0, ph[31:16], 1'b0});

    always_comb
    begin
        case (wf_reg[idx_reg])
            WAVE_TRI:
            begin
                if (!ph[31])
                begin
                    wave = tri_lin - 18'sd32768;
                end
                else
                begin
                    wave = 18'sd98303 - tri_lin;
                end
            end
            WAVE_SQUARE: wave = ph[31] ? 18'sd32767 : -18'sd32768;
            WAVE_SAW:    wave = 18'($signed(ph[31:16]));
            WAVE_PULSE:  wave = (ph[31:29] == 3'd0) ? 18'sd32767 : -18'sd16384;
            default:     wave = 18'($signed(noise_c[31:16]));
        endcase
    end

    // Voice output is the product shifted right with floor rounding.
    assign term = ACC_W'(prod >>> 11);

    always_comb
    begin
        if (acc_reg > ACC_W'(32767))
        begin
            mix_clamped = 16'sh7fff;
        end
        else if (acc_reg < -ACC_W'(32768))
        begin
            mix_clamped = -16'sh8000;
        end
        else
        begin
            mix_clamped = acc_reg[15:0];
        end
    end

    // Next state and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_TICK)
                    begin
                        state_next = ST_SEL;
                    end
                    else if (mode == MODE_NOTE_ON && value != 7'd0)
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                if (found || is_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_IDLE;
            end
            ST_SEL:
            begin
                if (active_reg[idx_reg])
                begin
                    state_next = ST_G1;
                end
                else if (is_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_G1:
            begin
                mul_a      = 18'($unsigned(vel_reg[idx_reg]));
                mul_b      = 18'($unsigned(chvol_reg[vchan_reg[idx_reg]]));
                state_next = ST_G2;
            end
            ST_G2:
            begin
                mul_a      = prod[17:0];
                mul_b      = 18'($unsigned(master_reg));
                state_next = ST_G3;
            end
            ST_G3:
            begin
                if (vchan_reg[idx_reg] == PERC_CHANNEL)
                begin
                    mul_a      = 18'($unsigned(gain_g3));
                    mul_b      = 18'($unsigned(perc_reg));
                    state_next = ST_G4;
                end
                else
                begin
                    state_next = ST_WAVE;
                end
            end
            ST_G4:
            begin
                mul_a      = prod[17:0];
                mul_b      = DIV100_RECIP;
                state_next = ST_G5;
            end
            ST_G5:
            begin
                state_next = ST_WAVE;
            end
            ST_WAVE:
            begin
                mul_a      = wave;
                mul_b      = 18'($unsigned(gain_reg));
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = is_last ? ST_OUT : ST_SEL;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= 7'd64;
            perc_reg   <= 7'd100;
            half_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MASTER: master_reg <= cfg_data;
                CFG_PERC:   perc_reg   <= cfg_data;
                CFG_HALF:   half_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Output register: loaded at the end of a tick, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            sample_reg <= mix_clamped;
        end
    end

    // Velocity of the note being started, captured at accept time.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            val_reg <= value;
        end
    end

    // Voice, channel and working state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                phase_reg[i] <= '0;
                step_reg[i]  <= '0;
                age_reg[i]   <= '0;
                note_reg[i]  <= '0;
                vchan_reg[i] <= '0;
                vel_reg[i]   <= '0;
                wf_reg[i]    <= '0;
            end
            active_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                chvol_reg[c] <= VOL_DEFAULT;
                prog_reg[c]  <= '0;
            end
            counter_reg <= '0;
            noise_reg   <= NOISE_SEED;
            idx_reg     <= '0;
            old_reg     <= '0;
            pick_reg    <= '0;
            ch_reg      <= '0;
            key_reg     <= '0;
            gain_reg    <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ch_reg   <= channel;
                        key_reg  <= key;
                        idx_reg  <= '0;
                        old_reg  <= '0;
                        pick_reg <= '0;
                        acc_reg  <= '0;
                        case (mode)
                            MODE_NOTE_ON, MODE_NOTE_OFF:
                            begin
                                // A note on with zero velocity is a release.
                                if (mode == MODE_NOTE_OFF || value == 7'd0)
                                begin
                                    for (int i = 0; i < VOICES; i++)
                                    begin
                                        if (vchan_reg[i] == channel && note_reg[i] == key)
                                        begin
                                            active_reg[i] <= 1'b0;
                                        end
                                    end
                                end
                            end
                            MODE_PROGRAM:
                            begin
                                prog_reg[channel] <= key;
                            end
                            MODE_CTRL:
                            begin
                                if (key == CC_VOLUME)
                                begin
                                    chvol_reg[channel] <= value;
                                end
                                else if (key == CC_ALL_OFF)
                                begin
                                    for (int i = 0; i < VOICES; i++)
                                    begin
                                        if (vchan_reg[i] == channel)
                                        begin
                                            active_reg[i] <= 1'b0;
                                        end
                                    end
                                end
                            end
                            MODE_SILENCE, MODE_RESTART:
                            begin
                                for (int i = 0; i < VOICES; i++)
                                begin
                                    phase_reg[i] <= '0;
                                    step_reg[i]  <= '0;
                                    age_reg[i]   <= '0;
                                    note_reg[i]  <= '0;
                                    vchan_reg[i] <= '0;
                                    vel_reg[i]   <= '0;
                                    wf_reg[i]    <= '0;
                                end
                                active_reg <= '0;
                                if (mode == MODE_RESTART)
                                begin
                                    for (int c = 0; c < CHANNELS; c++)
                                    begin
                                        chvol_reg[c] <= VOL_DEFAULT;
                                        prog_reg[c]  <= '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PICK:
                begin
                    // First free or matching voice wins, else the oldest.
                    if (found)
                    begin
                        pick_reg <= idx_reg;
                    end
                    else
                    begin
                        old_reg  <= old_cand;
                        pick_reg <= old_cand;
                        if (!is_last)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_START:
                begin
                    phase_reg[pick_reg]  <= '0;
                    step_reg[pick_reg]   <= pitch_step(key_reg, half_reg);
                    counter_reg          <= counter_reg + 32'd1;
                    age_reg[pick_reg]    <= counter_reg + 32'd1;
                    note_reg[pick_reg]   <= key_reg;
                    vchan_reg[pick_reg]  <= ch_reg;
                    vel_reg[pick_reg]    <= val_reg;
                    wf_reg[pick_reg]     <= (ch_reg == PERC_CHANNEL) ? WAVE_NOISE
                                          : {1'b0, prog_reg[ch_reg][5:4]};
                    active_reg[pick_reg] <= 1'b1;
                end
                ST_SEL:
                begin
                    if (!active_reg[idx_reg] && !is_last)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_G3:
                begin
                    gain_reg <= gain_g3;
                end
                ST_G5:
                begin
                    gain_reg <= gain_g5;
                end
                ST_WAVE:
                begin
                    phase_reg[idx_reg] <= ph + step_reg[idx_reg];
                    if (wf_reg[idx_reg] > WAVE_PULSE)
                    begin
                        noise_reg <= noise_c;
                    end
                end
                ST_ACC:
                begin
                    acc_reg <= acc_reg + term;
                    if (!is_last)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // The voice index never leaves the voice range.
    assert property (@(posedge clk) disable iff (!rst_n) idx_reg <= LAST_IDX)
        else $error("voice index out of range");

    // A tick always starts the sequencer on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode == MODE_TICK) |=> (state_reg == ST_SEL))
        else $error("tick did not start the voice walk");

    // Gain is clamped at its maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAVE) |-> (gain_reg <= GAIN_MAX))
        else $error("gain above maximum");

    // A new voice is active right after it is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |=> active_reg[$past(pick_reg)])
        else $error("started voice not active");

endmodule
